>>> rtl/hpc_pkg.sv
// Shared widths, codes and the saturating sign-apply helper for the hue preserving clamp.
// Used by hpc_div, the top level hue_preserving_clamp and its checker.
package hpc_pkg;

  // Sample and register widths.
  localparam int SW     = 16;
  localparam int UPW    = 15;
  localparam int LVW    = 16;
  localparam int NCH    = 3;
  localparam int TDW    = NCH * SW;

  // Divider geometry: dividend holds a product, quotient gets one bit per step.
  localparam int DW     = 16;
  localparam int QW     = 16;
  localparam int NW     = DW + QW;
  localparam int DIV_LAT = QW + 1;

  // Configuration port.
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] CFG_UPPER = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_LOWER = 1'b1;
  localparam logic [UPW-1:0] UPPER_RESET = 15'd4096;
  localparam logic [LVW-1:0] LOWER_RESET = 16'd0;

  // Result flag positions in out_tuser.
  localparam int FLAG_SAT   = 0;
  localparam int FLAG_FAULT = 1;

  localparam logic [QW-1:0] SMAX_MAG = 16'h7FFF;
  localparam logic [QW-1:0] SMIN_MAG = 16'h8000;

  typedef logic signed [SW-1:0] sample_t;

  // Applies the sign to an unsigned quotient and clamps to the sample range.
  // Bit SW of the result is the saturation flag.
  function automatic logic [SW:0] sign_clamp(input logic [QW-1:0] q, input logic ovf,
                                             input logic neg);
    logic [SW:0] r;
    if (neg) begin
      if (ovf || (q > SMIN_MAG)) r = {1'b1, SMIN_MAG};
      else r = {1'b0, SW'(-q)};
    end else begin
      if (ovf || q[QW-1]) r = {1'b1, SMAX_MAG};
      else r = {1'b0, SW'(q)};
    end
    return r;
  endfunction

endpackage

>>> rtl/hpc_div.sv
// Pipelined restoring divider: three dividends over one shared divisor, one quotient
// bit per stage, with a side tag carried along. Depends on hpc_pkg.
module hpc_div #(
  parameter int TAG_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 ce,
  input  logic                                 in_valid,
  input  logic [2:0][hpc_pkg::NW-1:0]          in_num,
  input  logic [hpc_pkg::DW-1:0]               in_den,
  input  logic [TAG_W-1:0]                     in_tag,
  output logic                                 out_valid,
  output logic [2:0][hpc_pkg::QW-1:0]          out_quo,
  output logic [2:0]                           out_ovf,
  output logic [TAG_W-1:0]                     out_tag
);
  import hpc_pkg::*;

  logic [2:0][NW-1:0] n_r   [0:QW-1];
  logic [DW-1:0]      den_r [0:QW-1];
  logic [2:0][QW-1:0] q_r   [0:QW];
  logic [2:0]         ovf_r [0:QW];
  logic [TAG_W-1:0]   tag_r [0:QW];
  logic               v_r   [0:QW];

  // Entry stage: flag quotients that cannot fit in QW bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0] ovf;
    if (ce) begin
      for (int j = 0; j < 3; j++) begin
        ovf[j] = (in_num[j] >= {in_den, {QW{1'b0}}});
      end
      ovf_r[0] <= ovf;
      n_r[0]   <= in_num;
      den_r[0] <= in_den;
      q_r[0]   <= '0;
      tag_r[0] <= in_tag;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [2:0][NW-1:0] n_nxt;
    logic [2:0]         bit_nxt;
    logic [2:0][QW-1:0] q_nxt;

    always_comb begin
      logic [NW-1:0] dsh;
      logic [NW:0]   trial;
      dsh = NW'(den_r[k-1]) << (QW - k);
      for (int j = 0; j < 3; j++) begin
        trial      = {1'b0, n_r[k-1][j]} - {1'b0, dsh};
        bit_nxt[j] = !trial[NW];
        n_nxt[j]   = bit_nxt[j] ? trial[NW-1:0] : n_r[k-1][j];
        q_nxt[j]   = {q_r[k-1][j][QW-2:0], bit_nxt[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end

    // The last stage needs no remainder.
    if (k < QW) begin : g_rem
      always_ff @(posedge clk) begin
        if (ce) begin
          n_r[k]   <= n_nxt;
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quo   = q_r[QW];
  assign out_ovf   = ovf_r[QW];
  assign out_tag   = tag_r[QW];

endmodule

>>> rtl/hue_preserving_clamp.sv
// Hue preserving clamp: scales an RGB pixel down to the upper level, then
// rescales it against the lower level. Depends on hpc_pkg and hpc_div.
// The path from input request to result runs through two 17-stage dividers.
// Throughput: one pixel per clock; the whole pipeline holds while a result waits.
// Reset (rst_n low, synchronous) clears all valid bits and loads upper 4096, lower 0.
module hue_preserving_clamp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [hpc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [hpc_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [hpc_pkg::TDW-1:0]    in_tdata,   // red_in, green_in, blue_in
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hpc_pkg::TDW-1:0]    out_tdata,  // red_out, green_out, blue_out
  output logic [1:0]                 out_tuser,  // saturated, divide_fault
  output logic                       out_tlast
);
  import hpc_pkg::*;

  localparam int TAG1_W = TDW + 2;
  localparam int TAG2_W = TDW + 3 + 3;

  logic [UPW-1:0] upper_r;
  sample_t        lower_r;
  logic           ce;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RESET;
      lower_r <= LOWER_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_UPPER: upper_r <= cfg_wdata[UPW-1:0];
        CFG_LOWER: lower_r <= cfg_wdata[LVW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being drained.
  logic out_v_r;
  assign ce        = !out_v_r || out_tready;
  assign in_tready = ce;

  // Stage 1: peak of the upper level and the channels.
  sample_t s1_ch_nxt [0:2];
  logic signed [SW:0] peak_nxt;
  always_comb begin
    logic signed [SW:0] ext;
    peak_nxt = {2'b00, upper_r};
    for (int j = 0; j < 3; j++) begin
      s1_ch_nxt[j] = in_tdata[j*SW +: SW];
      ext = {s1_ch_nxt[j][SW-1], s1_ch_nxt[j]};
      if (ext > peak_nxt) peak_nxt = ext;
    end
  end

  sample_t       s1_ch_r [0:2];
  logic [DW-1:0] s1_peak_r;
  logic          s1_need_r, s1_last_r, s1_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (ce) s1_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      s1_ch_r   <= s1_ch_nxt;
      s1_peak_r <= peak_nxt[DW-1:0];
      s1_need_r <= (peak_nxt != {2'b00, upper_r});
      s1_last_r <= in_tlast;
    end
  end

  // Stage 2: magnitude times upper level, divisor select.
  logic [2:0][NW-1:0] s2_num_r;
  logic [DW-1:0]      s2_den_r;
  logic [TAG1_W-1:0]  s2_tag_r;
  logic               s2_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (ce) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    logic [SW-1:0]      mag;
    logic [2:0][NW-1:0] num;
    logic [TAG1_W-1:0]  tag;
    if (ce) begin
      for (int j = 0; j < 3; j++) begin
        mag = s1_ch_r[j][SW-1] ? SW'(-s1_ch_r[j]) : SW'(s1_ch_r[j]);
        num[j] = NW'(mag) * NW'(upper_r);
        tag[j*SW +: SW] = s1_ch_r[j];
      end
      tag[TDW +: 2] = {s1_need_r, s1_last_r};
      s2_num_r <= num;
      s2_tag_r <= tag;
      s2_den_r <= s1_need_r ? s1_peak_r : DW'(1);
    end
  end

  logic               d1_v;
  logic [2:0][QW-1:0] d1_q;
  logic [2:0]         d1_ovf;
  logic [TAG1_W-1:0]  d1_tag;
  hpc_div #(.TAG_W(TAG1_W)) u_div_upper (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .in_valid(s2_v_r), .in_num(s2_num_r), .in_den(s2_den_r), .in_tag(s2_tag_r),
    .out_valid(d1_v), .out_quo(d1_q), .out_ovf(d1_ovf), .out_tag(d1_tag)
  );

  // Stage 3: signed stage-one values.
  sample_t s3_c_r [0:2];
  logic    s3_last_r, s3_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (ce) s3_v_r <= d1_v;
  end
  always_ff @(posedge clk) begin
    logic [SW:0] r;
    if (ce) begin
      for (int j = 0; j < 3; j++) begin
        r = sign_clamp(d1_q[j], d1_ovf[j], d1_tag[j*SW + SW - 1]);
        s3_c_r[j] <= d1_tag[TDW+1] ? r[SW-1:0] : d1_tag[j*SW +: SW];
      end
      s3_last_r <= d1_tag[TDW];
    end
  end

  // Stage 4: trough against the lower level.
  sample_t trough_nxt;
  always_comb begin
    trough_nxt = lower_r;
    for (int j = 0; j < 3; j++) begin
      if (s3_c_r[j] < trough_nxt) trough_nxt = s3_c_r[j];
    end
  end

  sample_t s4_c_r [0:2];
  sample_t s4_trough_r;
  logic    s4_need_r, s4_fault_r, s4_last_r, s4_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (ce) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      s4_c_r      <= s3_c_r;
      s4_trough_r <= trough_nxt;
      s4_need_r   <= (trough_nxt != lower_r);
      s4_fault_r  <= (trough_nxt != lower_r) && (trough_nxt == '0);
      s4_last_r   <= s3_last_r;
    end
  end

  // Stage 5: magnitude products with the lower level and quotient signs.
  logic [2:0][NW-1:0] s5_num_r;
  logic [DW-1:0]      s5_den_r;
  logic [TAG2_W-1:0]  s5_tag_r;
  logic               s5_v_r;
  logic [SW-1:0]      low_mag;
  logic               do2;
  assign low_mag = lower_r[SW-1] ? SW'(-lower_r) : SW'(lower_r);
  assign do2     = s4_need_r && !s4_fault_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (ce) s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    logic [SW-1:0]      mag;
    logic [2:0][NW-1:0] num;
    logic [TAG2_W-1:0]  tag;
    if (ce) begin
      for (int j = 0; j < 3; j++) begin
        mag = s4_c_r[j][SW-1] ? SW'(-s4_c_r[j]) : SW'(s4_c_r[j]);
        num[j] = NW'(mag) * NW'(low_mag);
        tag[j*SW +: SW] = s4_c_r[j];
        tag[TDW + j] = s4_c_r[j][SW-1] ^ lower_r[SW-1] ^ s4_trough_r[SW-1];
      end
      tag[TDW+3 +: 3] = {do2, s4_fault_r, s4_last_r};
      s5_num_r <= num;
      s5_tag_r <= tag;
      s5_den_r <= do2 ? (s4_trough_r[SW-1] ? DW'(-s4_trough_r) : DW'(s4_trough_r)) : DW'(1);
    end
  end

  logic               d2_v;
  logic [2:0][QW-1:0] d2_q;
  logic [2:0]         d2_ovf;
  logic [TAG2_W-1:0]  d2_tag;
  hpc_div #(.TAG_W(TAG2_W)) u_div_lower (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .in_valid(s5_v_r), .in_num(s5_num_r), .in_den(s5_den_r), .in_tag(s5_tag_r),
    .out_valid(d2_v), .out_quo(d2_q), .out_ovf(d2_ovf), .out_tag(d2_tag)
  );

  // Output register: final values and flags.
  logic [TDW-1:0] out_data_r;
  logic           out_sat_r, out_fault_r, out_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (ce) out_v_r <= d2_v;
  end
  always_ff @(posedge clk) begin
    logic [SW:0]    r;
    logic           sat;
    logic [TDW-1:0] data;
    if (ce) begin
      sat = 1'b0;
      for (int j = 0; j < 3; j++) begin
        r = sign_clamp(d2_q[j], d2_ovf[j], d2_tag[TDW + j]);
        data[j*SW +: SW] = d2_tag[TDW+5] ? r[SW-1:0] : d2_tag[j*SW +: SW];
        sat = sat | (d2_tag[TDW+5] & r[SW]);
      end
      out_data_r  <= data;
      out_sat_r   <= sat;
      out_fault_r <= d2_tag[TDW+4];
      out_last_r  <= d2_tag[TDW+3];
    end
  end

  assign out_tvalid            = out_v_r;
  assign out_tdata             = out_data_r;
  assign out_tuser[FLAG_SAT]   = out_sat_r;
  assign out_tuser[FLAG_FAULT] = out_fault_r;
  assign out_tlast             = out_last_r;

endmodule

>>> rtl/hpc_chk.sv
// Port-level checker for hue_preserving_clamp, attached by a bind statement.
// Depends on hpc_pkg.
module hpc_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_we,
  input logic [hpc_pkg::CFG_AW-1:0] cfg_addr,
  input logic [hpc_pkg::CFG_DW-1:0] cfg_wdata,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [hpc_pkg::TDW-1:0]    in_tdata,
  input logic                       in_tlast,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [hpc_pkg::TDW-1:0]    out_tdata,
  input logic [1:0]                 out_tuser,
  input logic                       out_tlast
);
  import hpc_pkg::*;

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // A divide fault, which skips the lower stage, never reports saturation.
  a_fault_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[FLAG_FAULT] |-> !out_tuser[FLAG_SAT])
    else $error("divide fault and saturation together");

  // A held result stalls the whole pipeline, input included.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind hue_preserving_clamp hpc_chk u_hpc_chk (.*);

>>> tb/hue_preserving_clamp_test.sv
// Self-checking testbench for the hue preserving clamp: directed and random pixels,
// several level settings, random stalls on both sides. Depends on hpc_pkg and the RTL.
module hue_preserving_clamp_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  // One expected result pixel.
  typedef struct packed {
    logic [SW-1:0] red;
    logic [SW-1:0] green;
    logic [SW-1:0] blue;
    logic          sat;
    logic          fault;
    logic          last;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDW-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  // Shadow copy of the level registers.
  logic [UPW-1:0] upper_shadow = UPPER_RESET;
  logic signed [LVW-1:0] lower_shadow = LOWER_RESET;

  pixel_result_t clamped_pixels[$];
  int errors = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit settings_swept_max = 1'b0;

  hue_preserving_clamp dut (.*);

  always #5 clk = ~clk;

  // Scale one channel by num/den with truncation and clamping.
  function automatic longint scale_ch(longint c, longint num, longint den, ref bit sat);
    longint q;
    q = (c * num) / den;
    if (q > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (q < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return q;
  endfunction

  // Computes the clamped pixel for the current level settings.
  function automatic pixel_result_t clamp_pixel(logic signed [SW-1:0] r, g, b, logic lst);
    longint ch[3];
    longint up, lo, peak, trough;
    bit sat;
    bit fault;
    pixel_result_t res;
    sat = 1'b0;
    fault = 1'b0;
    ch[0] = r;
    ch[1] = g;
    ch[2] = b;
    up = upper_shadow;
    lo = lower_shadow;
    peak = up;
    foreach (ch[i]) if (ch[i] > peak) peak = ch[i];
    if (peak > up) foreach (ch[i]) ch[i] = scale_ch(ch[i], up, peak, sat);
    trough = lo;
    foreach (ch[i]) if (ch[i] < trough) trough = ch[i];
    if (trough < lo) begin
      if (trough == 0) fault = 1'b1;
      else foreach (ch[i]) ch[i] = scale_ch(ch[i], lo, trough, sat);
    end
    res.red = ch[0][SW-1:0];
    res.green = ch[1][SW-1:0];
    res.blue = ch[2][SW-1:0];
    res.sat = sat;
    res.fault = fault;
    res.last = lst;
    return res;
  endfunction

  // Random gap: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Sends one pixel request and records its expected result. The valid line is
  // left high after the request so a following pixel can go back to back;
  // stop_input drops it when the sender pauses.
  task automatic send_pixel(logic [SW-1:0] r, g, b, logic lst, bit gaps = 1'b1);
    int gap;
    gap = gaps ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {b, g, r};
    in_tlast <= lst;
    in_tvalid <= 1'b1;
    clamped_pixels.push_back(clamp_pixel(r, g, b, lst));
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Drops the input valid line once the sender stops.
  task automatic stop_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic send_random_pixel(bit gaps = 1'b1);
    logic [SW-1:0] ch[3];
    int mode;
    foreach (ch[i]) begin
      mode = $urandom_range(9);
      if (mode == 0) ch[i] = '0;
      else if (mode < 4) ch[i] = SW'($signed($urandom_range(8192)) - 2048);
      else if (mode == 4) ch[i] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      else ch[i] = SW'($urandom);
    end
    send_pixel(ch[0], ch[1], ch[2], $urandom_range(15) == 0, gaps);
  endtask

  // Waits for every result, lets the pipeline drain, then writes a level.
  task automatic write_level(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
    stop_input();
    wait (clamped_pixels.size() == 0);
    repeat (DIV_LAT * 3) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_UPPER) upper_shadow = value[UPW-1:0];
    else lower_shadow = value;
  endtask

  // Result receiver with random stalls, suspended during a hold-off.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else begin
        gap = gap_len();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else out_tready <= 1'b1;
      end
    end
  end

  // Compares each result request with the oldest expected pixel.
  always @(posedge clk) begin
    pixel_result_t exp_pix;
    pixel_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32],
             out_tuser[FLAG_SAT], out_tuser[FLAG_FAULT], out_tlast};
      if (clamped_pixels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_pix = clamped_pixels.pop_front();
        pixels_checked++;
        if (got !== exp_pix) begin
          $display("%0t: mismatch expected r=%h g=%h b=%h sat=%b fault=%b last=%b",
                   $time, exp_pix.red, exp_pix.green, exp_pix.blue,
                   exp_pix.sat, exp_pix.fault, exp_pix.last);
          $display("%0t:          actual   r=%h g=%h b=%h sat=%b fault=%b last=%b",
                   $time, got.red, got.green, got.blue, got.sat, got.fault, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any request.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("hue_preserving_clamp regression: fail");
      $finish;
    end
  end

  // Extremes, zero trough and last marking at the reset levels.
  task automatic test_directed();
    send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_pixel(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
    send_pixel(16'h1000, 16'hF000, 16'h0800, 1'b0);
    send_pixel(16'hFFFF, 16'h0001, 16'h0FFF, 1'b1);
    send_pixel(16'h2000, 16'hFFFF, 16'h1000, 1'b0);
  endtask

  // Positive lower level: zero channel gives the fault, small ones saturate; then edge upper and lower levels.
  task automatic test_level_extremes();
    write_level(CFG_LOWER, 16'h7FFF);
    send_pixel(16'h0000, 16'h0100, 16'h0200, 1'b0);
    send_pixel(16'h0001, 16'h0002, 16'h0003, 1'b0);
    send_pixel(16'h8000, 16'h7FFF, 16'h0000, 1'b1);
    write_level(CFG_UPPER, 16'h0001);
    send_pixel(16'h7FFF, 16'h0001, 16'h0000, 1'b0);
    send_pixel(16'h0002, 16'hFFFF, 16'h0001, 1'b0);
    write_level(CFG_LOWER, 16'h8000);
    write_level(CFG_UPPER, 16'h7FFF);
    send_pixel(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'h7FFF, 1'b1);
    write_level(CFG_LOWER, 16'hF000);
    send_pixel(16'h8000, 16'h1000, 16'h0000, 1'b0);
    send_pixel(16'hFFFE, 16'h4000, 16'hC000, 1'b0);
    settings_swept_max = 1'b1;
  endtask

  // Random pixels over a series of random and edge level settings.
  task automatic test_random_levels();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_level(CFG_UPPER, 16'd4096);
          write_level(CFG_LOWER, 16'd0);
        end
        1: write_level(CFG_LOWER, 16'd256);
        default: begin
          write_level(CFG_UPPER, CFG_DW'($urandom_range(32767, 1)));
          write_level(CFG_LOWER, CFG_DW'($urandom));
        end
      endcase
      repeat (110) send_random_pixel();
    end
  endtask

  // Receiver holds off while the sender keeps going, so the input stalls.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (120) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        repeat (80) send_random_pixel(1'b0);
        stop_input();
      end
    join
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_level_extremes();
    test_random_levels();
    test_backpressure();
    stop_input();
    wait (clamped_pixels.size() == 0);
    repeat (DIV_LAT * 3) @(negedge clk);
    $display("Covered %0d pixels (%0d checked) over directed, edge and random levels,",
             pixels_sent, pixels_checked);
    $display("with random stalls on both sides and one long output hold-off.");
    if (errors == 0 && settings_swept_max) begin
      $display("hue_preserving_clamp regression: pass");
    end else begin
      $display("hue_preserving_clamp regression: fail");
    end
    $finish;
  end

endmodule
